/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the character stack RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/lcs_pkg.sv */
// Package for the character stack: action and status codes, item and result types,
// LCD and tone constants. It depends on nothing else.
package lcs_pkg;

	localparam int DEFAULT_DEPTH = 32;
	localparam int POS_W         = 5;
	localparam int DEPTH_W       = 6;

	localparam logic [6:0] LCD_ROW0_BASE = 7'h4F;
	localparam logic [4:0] LCD_ROW1_BASE = 5'd31;
	localparam logic [7:0] SPACE_CHAR    = 8'h20;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_PEEK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] item_char;
		logic       show;
		logic       tone;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [7:0]          top_char;
		logic                lcd_write;
		logic [6:0]          lcd_address;
		logic [7:0]          lcd_char;
		logic                tone_update;
		logic [15:0]         tone_period;
		logic [14:0]         tone_duty;
		logic [DEPTH_W-1:0]  depth;
		logic                is_full;
		logic                is_empty;
	} res_t;

	function automatic logic [15:0] tone_lookup(input logic [2:0] idx);
		logic [15:0] period;
		case (idx)
			3'd0: period = 16'd2505;
			3'd1: period = 16'd2231;
			3'd2: period = 16'd1988;
			3'd3: period = 16'd1876;
			3'd4: period = 16'd1672;
			3'd5: period = 16'd1489;
			3'd6: period = 16'd1327;
			3'd7: period = 16'd1252;
			default: period = 16'd2505;
		endcase
		return period;
	endfunction

endpackage

/* hw/rtl/lcs_map.sv */
// Maps stack entry positions to an LCD address and a buzzer period.
// Depends on lcs_pkg.
module lcs_map (
	input  logic [lcs_pkg::POS_W-1:0] lcd_pos,
	input  logic [lcs_pkg::POS_W-1:0] tone_pos,
	output logic [6:0]                lcd_address,
	output logic [15:0]               tone_period
);

	always_comb begin
		if (lcd_pos[4] == 1'b0) begin
			lcd_address = lcs_pkg::LCD_ROW0_BASE - {3'd0, lcd_pos[3:0]};
		end else begin
			lcd_address = {2'd0, lcs_pkg::LCD_ROW1_BASE - lcd_pos};
		end
	end

	assign tone_period = lcs_pkg::tone_lookup(tone_pos[4:2]);

endmodule

/* hw/rtl/lcs_core.sv */
// Stack storage, entry count and the decode of one item into its result.
// Depends on lcs_pkg, lcs_map and assert_macros.svh.
`include "assert_macros.svh"

module lcs_core #(
	parameter int STACK_DEPTH = lcs_pkg::DEFAULT_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          proc,
	input  lcs_pkg::req_t req,
	output lcs_pkg::res_t res
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [7:0]        store_q [STACK_DEPTH];
	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  push_idx;
	logic [IDX_W-1:0]  top_idx;
	logic [IDX_W-1:0]  pop_tidx;
	logic [IDX_W-1:0]  lcd_idx;
	logic [IDX_W-1:0]  tone_idx;
	logic [6:0]        map_addr;
	logic [15:0]       map_period;
	logic              do_push;

	assign full     = (count_q == CNT_W'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign push_idx = count_q[IDX_W-1:0];
	assign top_idx  = IDX_W'(count_q - CNT_W'(1));
	assign pop_tidx = (count_q >= CNT_W'(2)) ? IDX_W'(count_q - CNT_W'(2)) : '0;
	assign lcd_idx  = (req.action == lcs_pkg::ACT_PUSH) ? push_idx : top_idx;
	assign tone_idx = (req.action == lcs_pkg::ACT_PUSH) ? push_idx : pop_tidx;

	lcs_map u_map (
		.lcd_pos     (lcs_pkg::POS_W'(lcd_idx)),
		.tone_pos    (lcs_pkg::POS_W'(tone_idx)),
		.lcd_address (map_addr),
		.tone_period (map_period)
	);

	always_comb begin
		res       = '0;
		res.status = lcs_pkg::ST_OK;
		count_nxt = count_q;
		do_push   = 1'b0;
		case (req.action)
			lcs_pkg::ACT_PUSH: begin
				if (full) begin
					res.status = lcs_pkg::ST_FULL;
				end else begin
					do_push   = 1'b1;
					count_nxt = count_q + CNT_W'(1);
					if (req.show) begin
						res.lcd_write   = 1'b1;
						res.lcd_address = map_addr;
						res.lcd_char    = req.item_char;
					end
					if (req.tone) begin
						res.tone_update = 1'b1;
						res.tone_period = map_period;
						res.tone_duty   = map_period[15:1];
					end
				end
			end
			lcs_pkg::ACT_POP: begin
				if (empty) begin
					res.status = lcs_pkg::ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
					if (req.show) begin
						res.lcd_write   = 1'b1;
						res.lcd_address = map_addr;
						res.lcd_char    = lcs_pkg::SPACE_CHAR;
					end
					if (req.tone) begin
						res.tone_update = 1'b1;
						res.tone_period = map_period;
						res.tone_duty   = map_period[15:1];
					end
				end
			end
			lcs_pkg::ACT_PEEK: begin
				if (empty) begin
					res.status = lcs_pkg::ST_EMPTY;
				end else begin
					res.top_char = store_q[top_idx];
				end
			end
			lcs_pkg::ACT_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
		res.depth    = lcs_pkg::DEPTH_W'(count_nxt);
		res.is_full  = (count_nxt == CNT_W'(STACK_DEPTH));
		res.is_empty = (count_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (proc) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && do_push) begin
			store_q[push_idx] <= req.item_char;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(STACK_DEPTH), "entry count above stack depth")
	`ASSERT_NEXT(a_clear_empties, proc && req.action == lcs_pkg::ACT_CLEAR, count_q == '0,
		"clear did not empty the stack")
	`ASSERT_NEXT(a_push_grows, proc && do_push, count_q == $past(count_q) + CNT_W'(1),
		"accepted push did not add one entry")
	`ASSERT_ALWAYS(a_no_req_on_error,
		!proc || res.status == lcs_pkg::ST_OK || (!res.lcd_write && !res.tone_update),
		"LCD or tone request raised on an error")

endmodule

/* hw/rtl/lcd_char_stack_with_tone.sv */
// Top level of the character stack with LCD placement and buzzer tone.
// Depends on lcs_pkg, lcs_core and assert_macros.svh.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_ready  action, item_char, show, tone
//   output   out_valid/ out_ready status, top_char, lcd_write, lcd_address, lcd_char,
//                                 tone_update, tone_period, tone_duty, depth,
//                                 is_full, is_empty
//
// An item is held in the input register, decoded combinationally against the entry count
// and the stack registers, and lands in the result register when it moves on; one item per
// cycle is sustained while the output is not stalled. Reset empties the stack at once; the
// stored characters are not cleared. A stalled result holds both registers, and a new item
// is taken whenever the input register empties or moves on in that cycle.
`include "assert_macros.svh"

module lcd_char_stack_with_tone #(
	parameter int STACK_DEPTH = lcs_pkg::DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  item_char,
	input  logic        show,
	input  logic        tone,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  top_char,
	output logic        lcd_write,
	output logic [6:0]  lcd_address,
	output logic [7:0]  lcd_char,
	output logic        tone_update,
	output logic [15:0] tone_period,
	output logic [14:0] tone_duty,
	output logic [5:0]  depth,
	output logic        is_full,
	output logic        is_empty
);

	logic          valid_s1;
	logic          valid_s2;
	lcs_pkg::req_t req_s1;
	lcs_pkg::res_t res_s2;
	lcs_pkg::res_t res_comb;
	logic          advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	lcs_core #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (advance),
		.req    (req_s1),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= '{action: lcs_pkg::action_t'(action), item_char: item_char,
				show: show, tone: tone};
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign top_char    = res_s2.top_char;
	assign lcd_write   = res_s2.lcd_write;
	assign lcd_address = res_s2.lcd_address;
	assign lcd_char    = res_s2.lcd_char;
	assign tone_update = res_s2.tone_update;
	assign tone_period = res_s2.tone_period;
	assign tone_duty   = res_s2.tone_duty;
	assign depth       = res_s2.depth;
	assign is_full     = res_s2.is_full;
	assign is_empty    = res_s2.is_empty;

	`ASSERT_ALWAYS(a_full_empty_excl, !valid_s2 || !(is_full && is_empty),
		"result both full and empty")
	`ASSERT_NEXT(a_advance_fills, advance, valid_s2, "processed item did not reach the result register")

endmodule

/* tb/sv/lcd_char_stack_with_tone_tb.sv */
// Self-checking testbench for the character stack with LCD placement and buzzer tone.
// A stimulus table and random operation bursts are checked against typed results or a behavioural predictor.
// Depends on lcs_pkg and the lcd_char_stack_with_tone RTL.
`timescale 1ns / 100ps

module lcd_char_stack_with_tone_tb;

	localparam int DEPTH        = lcs_pkg::DEFAULT_DEPTH;
	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam logic [15:0] TONE_PERIODS [8] = '{
		16'd2505, 16'd2231, 16'd1988, 16'd1876, 16'd1672, 16'd1489, 16'd1327, 16'd1252
	};

	typedef struct {
		lcs_pkg::action_t act;
		logic [7:0]       ch;
		logic             sh;
		logic             tn;
		bit               typed;
		lcs_pkg::res_t    want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = lcs_pkg::ACT_PEEK;
	logic [7:0]  item_char = 8'h00;
	logic        show = 1'b0;
	logic        tone = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  top_char;
	logic        lcd_write;
	logic [6:0]  lcd_address;
	logic [7:0]  lcd_char;
	logic        tone_update;
	logic [15:0] tone_period;
	logic [14:0] tone_duty;
	logic [5:0]  depth;
	logic        is_full;
	logic        is_empty;

	logic [7:0]    stack_chars [DEPTH];
	int unsigned   stack_fill = 0;
	lcs_pkg::res_t pending_res [$];
	dir_row_t      dir_tab [$];
	int unsigned   mismatch_cnt = 0;
	int unsigned   cycle_cnt = 0;
	int unsigned   tx_idle_pct = 28;
	int unsigned   rx_idle_pct = 28;
	int unsigned   hold_left = 0;

	lcd_char_stack_with_tone dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .item_char(item_char), .show(show), .tone(tone),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .top_char(top_char), .lcd_write(lcd_write),
		.lcd_address(lcd_address), .lcd_char(lcd_char), .tone_update(tone_update),
		.tone_period(tone_period), .tone_duty(tone_duty), .depth(depth),
		.is_full(is_full), .is_empty(is_empty)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [6:0] lcd_slot(input int unsigned pos);
		return (pos < 16) ? 7'(8'h4F - pos) : 7'(31 - pos);
	endfunction

	function automatic lcs_pkg::res_t stack_op_result(input lcs_pkg::action_t act,
			input logic [7:0] ch, input logic sh, input logic tn);
		lcs_pkg::res_t r;
		int unsigned pos;
		int unsigned tidx;
		r = '0;
		r.status = lcs_pkg::ST_OK;
		case (act)
			lcs_pkg::ACT_PUSH: begin
				if (stack_fill >= DEPTH) begin
					r.status = lcs_pkg::ST_FULL;
				end else begin
					pos = stack_fill;
					if (sh) begin
						r.lcd_write   = 1'b1;
						r.lcd_address = lcd_slot(pos);
						r.lcd_char    = ch;
					end
					if (tn) begin
						r.tone_update = 1'b1;
						r.tone_period = TONE_PERIODS[(pos / 4) % 8];
					end
					stack_chars[pos] = ch;
					stack_fill++;
				end
			end
			lcs_pkg::ACT_POP: begin
				if (stack_fill == 0) begin
					r.status = lcs_pkg::ST_EMPTY;
				end else begin
					pos  = stack_fill - 1;
					// The last entry out takes the first tone rather than wrapping.
					tidx = (stack_fill >= 2) ? stack_fill - 2 : 0;
					if (sh) begin
						r.lcd_write   = 1'b1;
						r.lcd_address = lcd_slot(pos);
						r.lcd_char    = lcs_pkg::SPACE_CHAR;
					end
					if (tn) begin
						r.tone_update = 1'b1;
						r.tone_period = TONE_PERIODS[(tidx / 4) % 8];
					end
					stack_fill--;
				end
			end
			lcs_pkg::ACT_PEEK: begin
				if (stack_fill == 0) begin
					r.status = lcs_pkg::ST_EMPTY;
				end else begin
					r.top_char = stack_chars[stack_fill - 1];
				end
			end
			default: begin
				stack_fill = 0;
			end
		endcase
		r.tone_duty = 15'(r.tone_period >> 1);
		r.depth     = 6'(stack_fill);
		r.is_full   = (stack_fill == DEPTH);
		r.is_empty  = (stack_fill == 0);
		return r;
	endfunction

	task automatic add_row(input lcs_pkg::action_t act, input logic [7:0] ch,
			input logic sh, input logic tn, input bit typed, input lcs_pkg::res_t want);
		dir_row_t row;
		row.act   = act;
		row.ch    = ch;
		row.sh    = sh;
		row.tn    = tn;
		row.typed = typed;
		row.want  = want;
		dir_tab.push_back(row);
	endtask

	task automatic send_item(input lcs_pkg::action_t act, input logic [7:0] ch,
			input logic sh, input logic tn, input bit typed, input lcs_pkg::res_t fixed);
		lcs_pkg::res_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		item_char <= ch;
		show      <= sh;
		tone      <= tn;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = stack_op_result(act, ch, sh, tn);
		pending_res.push_back(typed ? fixed : predicted);
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		lcs_pkg::res_t want;
		if (out_valid && out_ready) begin
			if (pending_res.size() == 0) begin
				$error("unexpected result: status %0d, depth %0d", status, depth);
				mismatch_cnt++;
			end else begin
				want = pending_res.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_cnt++;
				end
				if (top_char !== want.top_char) begin
					$error("top_char: expected %0d, got %0d", want.top_char, top_char);
					mismatch_cnt++;
				end
				if (lcd_write !== want.lcd_write) begin
					$error("lcd_write: expected %0d, got %0d", want.lcd_write, lcd_write);
					mismatch_cnt++;
				end
				if (lcd_address !== want.lcd_address) begin
					$error("lcd_address: expected %0d, got %0d",
						want.lcd_address, lcd_address);
					mismatch_cnt++;
				end
				if (lcd_char !== want.lcd_char) begin
					$error("lcd_char: expected %0d, got %0d", want.lcd_char, lcd_char);
					mismatch_cnt++;
				end
				if (tone_update !== want.tone_update) begin
					$error("tone_update: expected %0d, got %0d",
						want.tone_update, tone_update);
					mismatch_cnt++;
				end
				if (tone_period !== want.tone_period) begin
					$error("tone_period: expected %0d, got %0d",
						want.tone_period, tone_period);
					mismatch_cnt++;
				end
				if (tone_duty !== want.tone_duty) begin
					$error("tone_duty: expected %0d, got %0d", want.tone_duty, tone_duty);
					mismatch_cnt++;
				end
				if (depth !== want.depth) begin
					$error("depth: expected %0d, got %0d", want.depth, depth);
					mismatch_cnt++;
				end
				if (is_full !== want.is_full) begin
					$error("is_full: expected %0d, got %0d", want.is_full, is_full);
					mismatch_cnt++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL lcd_char_stack_with_tone");
			$finish;
		end
	end

	initial begin
		int unsigned      sent;
		int unsigned      seg;
		int unsigned      len;
		int unsigned      mode;
		int unsigned      pick;
		lcs_pkg::action_t act;

		// Rows with a typed result are the plain cases: empty stack, clear and one entry.
		add_row(lcs_pkg::ACT_POP, 8'h00, 1'b1, 1'b1, 1'b1, lcs_pkg::res_t'{lcs_pkg::ST_EMPTY,
			8'h00, 1'b0, 7'h00, 8'h00, 1'b0, 16'd0, 15'd0, 6'd0, 1'b0, 1'b1});
		add_row(lcs_pkg::ACT_PEEK, 8'h00, 1'b1, 1'b1, 1'b1, lcs_pkg::res_t'{lcs_pkg::ST_EMPTY,
			8'h00, 1'b0, 7'h00, 8'h00, 1'b0, 16'd0, 15'd0, 6'd0, 1'b0, 1'b1});
		add_row(lcs_pkg::ACT_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b1, lcs_pkg::res_t'{lcs_pkg::ST_OK,
			8'h00, 1'b0, 7'h00, 8'h00, 1'b0, 16'd0, 15'd0, 6'd0, 1'b0, 1'b1});
		add_row(lcs_pkg::ACT_PUSH, 8'hFF, 1'b1, 1'b1, 1'b1, lcs_pkg::res_t'{lcs_pkg::ST_OK,
			8'h00, 1'b1, 7'h4F, 8'hFF, 1'b1, 16'd2505, 15'd1252, 6'd1, 1'b0, 1'b0});
		add_row(lcs_pkg::ACT_PEEK, 8'h00, 1'b1, 1'b1, 1'b1, lcs_pkg::res_t'{lcs_pkg::ST_OK,
			8'hFF, 1'b0, 7'h00, 8'h00, 1'b0, 16'd0, 15'd0, 6'd1, 1'b0, 1'b0});
		add_row(lcs_pkg::ACT_POP, 8'h00, 1'b1, 1'b1, 1'b1, lcs_pkg::res_t'{lcs_pkg::ST_OK,
			8'h00, 1'b1, 7'h4F, 8'h20, 1'b1, 16'd2505, 15'd1252, 6'd0, 1'b0, 1'b1});
		add_row(lcs_pkg::ACT_PUSH, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(lcs_pkg::ACT_PUSH, 8'hA5, 1'b1, 1'b0, 1'b0, '0);
		add_row(lcs_pkg::ACT_PUSH, 8'h5A, 1'b0, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_PUSH, 8'h3C, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_PUSH, 8'hC3, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_PEEK, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_POP, 8'hFF, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_POP, 8'h00, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_POP, 8'h00, 1'b0, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_POP, 8'h00, 1'b1, 1'b0, 1'b0, '0);
		add_row(lcs_pkg::ACT_POP, 8'h00, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_POP, 8'h00, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_PUSH, 8'h7E, 1'b1, 1'b1, 1'b0, '0);
		add_row(lcs_pkg::ACT_PUSH, 8'h81, 1'b0, 1'b0, 1'b0, '0);
		add_row(lcs_pkg::ACT_CLEAR, 8'h00, 1'b1, 1'b1, 1'b1, lcs_pkg::res_t'{lcs_pkg::ST_OK,
			8'h00, 1'b0, 7'h00, 8'h00, 1'b0, 16'd0, 15'd0, 6'd0, 1'b0, 1'b1});
		add_row(lcs_pkg::ACT_PEEK, 8'h00, 1'b0, 1'b0, 1'b0, '0);
		add_row(lcs_pkg::ACT_PUSH, 8'h55, 1'b1, 1'b1, 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].act, dir_tab[i].ch, dir_tab[i].sh, dir_tab[i].tn,
				dir_tab[i].typed, dir_tab[i].want);
		end

		// The first two bursts fill the stack past full and then empty it past empty.
		sent = 0;
		seg  = 0;
		while (sent < RANDOM_ITEMS) begin
			if (seg < 2) begin
				mode = seg;
				len  = DEPTH + 4;
			end else begin
				mode = $urandom_range(2);
				len  = $urandom_range(20, 60);
			end
			if (seg == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				len = 80;
			end else begin
				tx_idle_pct = 28;
				rx_idle_pct = 28;
			end
			if (seg == 3) begin
				hold_left = 60;
			end
			if (seg == 5 || seg == 9) begin
				drain_results();
			end
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(99);
				if (seg == 0) begin
					act = lcs_pkg::ACT_PUSH;
				end else if (seg == 1) begin
					act = lcs_pkg::ACT_POP;
				end else if (pick >= 97) begin
					act = lcs_pkg::ACT_CLEAR;
				end else if (pick >= 87) begin
					act = lcs_pkg::ACT_PEEK;
				end else if (mode == 0) begin
					act = (pick < 75) ? lcs_pkg::ACT_PUSH : lcs_pkg::ACT_POP;
				end else if (mode == 1) begin
					act = (pick < 75) ? lcs_pkg::ACT_POP : lcs_pkg::ACT_PUSH;
				end else begin
					act = (pick < 45) ? lcs_pkg::ACT_PUSH : lcs_pkg::ACT_POP;
				end
				send_item(act, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b0, '0);
				sent++;
			end
			seg++;
		end

		in_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("PASS lcd_char_stack_with_tone");
		end else begin
			$display("FAIL lcd_char_stack_with_tone");
		end
		$finish;
	end

endmodule
